/* sv/alu_flags_unit_macros.svh */
// Assertion macros for the ALU flags unit.
// Included by the top level; needs clk and rst_n in scope at the point of use.
`ifndef ALU_FLAGS_UNIT_MACROS_SVH
`define ALU_FLAGS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define AFU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alu_flags_unit: same-cycle check failed");
`define AFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alu_flags_unit: next-cycle check failed");
`else
`define AFU_ASSERT_NOW(lbl, ante, cons)
`define AFU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/afu_pkg.sv */
// Shared types and codes for the ALU flags unit.
// No dependencies; imported by afu_exec, afu_cond, alu_flags_unit, afu_flags_checker and alu_flags_unit_tb.
`timescale 1ns / 1ps

package afu_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_OR   = 4'd1,
        OP_ADC  = 4'd2,
        OP_SBB  = 4'd3,
        OP_AND  = 4'd4,
        OP_SUB  = 4'd5,
        OP_XOR  = 4'd6,
        OP_CMP  = 4'd7,
        OP_TEST = 4'd8,
        OP_NOT  = 4'd9,
        OP_NEG  = 4'd10,
        OP_SHL  = 4'd11,
        OP_SHR  = 4'd12,
        OP_SAR  = 4'd13,
        OP_COND = 4'd14
    } op_t;

    // condition group, code bits [3:1]; bit 0 inverts
    typedef enum logic [2:0] {
        CG_O   = 3'd0,
        CG_B   = 3'd1,
        CG_E   = 3'd2,
        CG_BE  = 3'd3,
        CG_S   = 3'd4,
        CG_P   = 3'd5,
        CG_L   = 3'd6,
        CG_LE  = 3'd7
    } cond_grp_t;

    typedef struct packed {
        logic ov;
        logic cy;
        logic sg;
        logic zf;
    } flags_t;

    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;
    localparam int COND_W = 4;
    localparam int CNT_W  = 8;

endpackage

/* sv/afu_cond.sv */
// Jump condition evaluation against the held flags.
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_cond (
    input  logic [afu_pkg::COND_W-1:0] condition,
    input  afu_pkg::flags_t            flags,
    output logic                       taken
);
    import afu_pkg::*;

    logic base;

    always_comb
    begin
        case (cond_grp_t'(condition[COND_W-1:1]))
            CG_O:    base = flags.ov;
            CG_B:    base = flags.cy;
            CG_E:    base = flags.zf;
            CG_BE:   base = flags.cy | flags.zf;
            CG_S:    base = flags.sg;
            CG_P:    base = 1'b1;   // parity not kept
            CG_L:    base = flags.sg ^ flags.ov;
            CG_LE:   base = flags.zf | (flags.sg ^ flags.ov);
            default: base = 1'b0;
        endcase
        taken = base ^ condition[0];
    end

endmodule

/* sv/afu_exec.sv */
// Arithmetic, logic and shift datapath with flag update.
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_exec (
    input  afu_pkg::op_t               operation,
    input  logic                       word_size,
    input  logic [afu_pkg::DATA_W-1:0] dest_value,
    input  logic [afu_pkg::DATA_W-1:0] source_value,
    input  afu_pkg::flags_t            flags_in,
    output logic [afu_pkg::DATA_W-1:0] result,
    output logic                       write_back,
    output afu_pkg::flags_t            flags_out
);
    import afu_pkg::*;

    localparam int SA_W = $clog2(DATA_W + 1);

    function automatic logic top_bit(input logic [DATA_W-1:0] v, input logic wd);
        top_bit = wd ? v[DATA_W-1] : v[BYTE_W-1];
    endfunction

    logic [DATA_W-1:0]   mask;
    logic [DATA_W-1:0]   d;
    logic [DATA_W-1:0]   s;
    logic [CNT_W-1:0]    cnt;
    logic                cin;
    logic [DATA_W:0]     add_sum;
    logic [DATA_W-1:0]   add_res;
    logic [DATA_W-1:0]   sub_a;
    logic [DATA_W-1:0]   sub_b;
    logic [DATA_W:0]     sub_diff;
    logic [DATA_W-1:0]   sub_res;
    logic [SA_W-1:0]     sa;
    logic                cnt_lt_w;
    logic                cnt_le_w;
    logic [2*DATA_W-1:0] shl_wide;
    logic [DATA_W:0]     shr_wide;
    logic [DATA_W-1:0]   sx;
    logic [DATA_W:0]     sar_wide;
    logic                neg;
    logic                shl_cy;
    logic [DATA_W-1:0]   res;
    logic                szf;
    flags_t              nf;

    assign mask = word_size ? {DATA_W{1'b1}} : {{(DATA_W-BYTE_W){1'b0}}, {BYTE_W{1'b1}}};
    assign d    = dest_value & mask;
    assign s    = source_value & mask;
    assign cnt  = source_value[CNT_W-1:0];
    assign cin  = ((operation == OP_ADC) || (operation == OP_SBB)) ? flags_in.cy : 1'b0;

    assign add_sum = {1'b0, d} + {1'b0, s} + {{DATA_W{1'b0}}, cin};
    assign add_res = add_sum[DATA_W-1:0] & mask;

    assign sub_a    = (operation == OP_NEG) ? '0 : d;
    assign sub_b    = (operation == OP_NEG) ? d : s;
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b} - {{DATA_W{1'b0}}, cin};
    assign sub_res  = sub_diff[DATA_W-1:0] & mask;

    assign sa       = (cnt > CNT_W'(DATA_W)) ? SA_W'(DATA_W) : cnt[SA_W-1:0];
    assign cnt_lt_w = word_size ? (cnt < CNT_W'(DATA_W)) : (cnt < CNT_W'(BYTE_W));
    assign cnt_le_w = word_size ? (cnt <= CNT_W'(DATA_W)) : (cnt <= CNT_W'(BYTE_W));
    assign neg      = top_bit(d, word_size);

    assign shl_wide = {{DATA_W{1'b0}}, d} << sa;
    assign shl_cy   = word_size ? shl_wide[DATA_W] : shl_wide[BYTE_W];
    assign shr_wide = {d, 1'b0} >> sa;
    assign sx       = word_size ? d : {{(DATA_W-BYTE_W){d[BYTE_W-1]}}, d[BYTE_W-1:0]};
    assign sar_wide = $signed({sx, 1'b0}) >>> sa;

    always_comb
    begin
        res        = '0;
        write_back = 1'b1;
        szf        = 1'b1;
        nf         = flags_in;
        case (operation)
            OP_ADD, OP_ADC:
            begin
                res   = add_res;
                nf.cy = word_size ? add_sum[DATA_W] : add_sum[BYTE_W];
                nf.ov = top_bit(~(d ^ s) & (d ^ add_res), word_size);
            end
            OP_SUB, OP_SBB, OP_CMP, OP_NEG:
            begin
                res        = sub_res;
                nf.cy      = sub_diff[DATA_W];
                nf.ov      = top_bit((sub_a ^ sub_b) & (sub_a ^ sub_res), word_size);
                write_back = (operation != OP_CMP);
            end
            OP_OR:
            begin
                res   = d | s;
                nf.ov = 1'b0;
                nf.cy = 1'b0;
            end
            OP_AND, OP_TEST:
            begin
                res        = d & s;
                nf.ov      = 1'b0;
                nf.cy      = 1'b0;
                write_back = (operation != OP_TEST);
            end
            OP_XOR:
            begin
                res   = d ^ s;
                nf.ov = 1'b0;
                nf.cy = 1'b0;
            end
            OP_NOT:
            begin
                res = ~d & mask;
                szf = 1'b0;
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                if (cnt == '0)
                begin
                    res = d;
                    szf = 1'b0;
                end
                else if (operation == OP_SHL)
                begin
                    res   = cnt_lt_w ? (shl_wide[DATA_W-1:0] & mask) : '0;
                    nf.cy = cnt_le_w ? shl_cy : 1'b0;
                    nf.ov = top_bit(res, word_size) ^ nf.cy;
                end
                else if (operation == OP_SHR)
                begin
                    res   = cnt_lt_w ? shr_wide[DATA_W:1] : '0;
                    nf.cy = cnt_le_w ? shr_wide[0] : 1'b0;
                    nf.ov = neg;
                end
                else
                begin
                    res   = cnt_lt_w ? (sar_wide[DATA_W:1] & mask) : (neg ? mask : '0);
                    nf.cy = cnt_le_w ? sar_wide[0] : neg;
                    nf.ov = 1'b0;
                end
            end
            default:
            begin
                write_back = 1'b0;
                szf        = 1'b0;
            end
        endcase
        if (szf)
        begin
            nf.sg = top_bit(res, word_size);
            nf.zf = (res == '0);
        end
    end

    assign result    = res;
    assign flags_out = nf;

endmodule

/* sv/alu_flags_unit.sv */
// Top level of the 8086-style ALU flags unit: stream ports, stage registers, flag state.
// Depends on afu_pkg, afu_exec, afu_cond and alu_flags_unit_macros.svh.
`timescale 1ns / 1ps
`include "alu_flags_unit_macros.svh"

// One item per clock, sustained while m_tready stays high. An accepted item sits in the
// input register, passes through the ALU datapath and the condition check, and is loaded
// into the output register, which raises m_tvalid, as soon as that register is free or
// being taken. The overflow, carry, sign and zero flags are updated as each item leaves
// the input register, so an item sees the flags left by the item just before it. A
// waiting result holds the next item in the input register; input stalls only when both
// registers are full, and the input register takes a new item whenever it is empty or
// moving on.
module alu_flags_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[3:0], dest_value[19:4], source_value[35:20], condition[39:36]
    input  logic [39:0] s_tdata,
    // word_size[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result[15:0], write_back[16], overflow_out[17], carry_out[18], sign_out[19],
    // zero_out[20], branch_taken[21], zero[23:22]
    output logic [23:0] m_tdata
);
    import afu_pkg::*;

    logic                in_vld_reg;
    logic                in_vld_next;
    op_t                 op_reg;
    logic                word_reg;
    logic [DATA_W-1:0]   dest_reg;
    logic [DATA_W-1:0]   src_reg;
    logic [COND_W-1:0]   cond_reg;

    logic                out_vld_reg;
    logic                out_vld_next;
    logic [DATA_W-1:0]   res_reg;
    logic                wb_reg;
    flags_t              out_flags_reg;
    logic                br_reg;

    flags_t              flags_reg;
    flags_t              flags_next;

    logic                out_free;
    logic                fire;
    logic                load;
    logic [DATA_W-1:0]   exec_res;
    logic                exec_wb;
    logic                cond_taken;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign load     = s_tvalid && s_tready;

    afu_exec u_exec (
        .operation    (op_reg),
        .word_size    (word_reg),
        .dest_value   (dest_reg),
        .source_value (src_reg),
        .flags_in     (flags_reg),
        .result       (exec_res),
        .write_back   (exec_wb),
        .flags_out    (flags_next)
    );

    afu_cond u_cond (
        .condition (cond_reg),
        .flags     (flags_reg),
        .taken     (cond_taken)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (load)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        out_vld_next = out_vld_reg;
        if (fire)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= op_t'(s_tdata[3:0]);
            dest_reg <= s_tdata[19:4];
            src_reg  <= s_tdata[35:20];
            cond_reg <= s_tdata[39:36];
            word_reg <= s_tuser;
        end
        if (fire)
        begin
            res_reg       <= exec_res;
            wb_reg        <= exec_wb;
            out_flags_reg <= flags_next;
            br_reg        <= (op_reg == OP_COND) && cond_taken;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, br_reg, out_flags_reg.zf, out_flags_reg.sg,
                       out_flags_reg.cy, out_flags_reg.ov, wb_reg, res_reg};

    `AFU_ASSERT_NEXT(a_flags_track, fire, (flags_reg == out_flags_reg))
    `AFU_ASSERT_NOW(a_branch_no_wb, (m_tvalid && m_tdata[21]), (!m_tdata[16] && (m_tdata[15:0] == '0)))
    `AFU_ASSERT_NEXT(a_in_hold, (in_vld_reg && !out_free), in_vld_reg)

endmodule

/* tb/afu_flags_checker.sv */
// Checker for alu_flags_unit: watches both stream channels, predicts each result
// from the accepted item and the flags it tracks, and compares in order.
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_flags_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import afu_pkg::*;

    typedef struct packed {
        logic [1:0]  pad;
        logic        br;
        logic        zf;
        logic        sg;
        logic        cy;
        logic        ov;
        logic        wb;
        logic [15:0] res;
    } alu_outcome_t;

    flags_t       flags;
    alu_outcome_t outcome_q[$];
    alu_outcome_t got;
    alu_outcome_t want;

    function automatic logic cond_holds(logic [3:0] code);
        logic base;
        case (cond_grp_t'(code[3:1]))
            CG_O:    base = flags.ov;
            CG_B:    base = flags.cy;
            CG_E:    base = flags.zf;
            CG_BE:   base = flags.cy | flags.zf;
            CG_S:    base = flags.sg;
            CG_P:    base = 1'b1;
            CG_L:    base = flags.sg ^ flags.ov;
            default: base = flags.zf | (flags.sg ^ flags.ov);
        endcase
        return base ^ code[0];
    endfunction

    // Computes one item's outcome and updates the tracked flags.
    function automatic alu_outcome_t alu_step(logic [3:0] op, logic wide, logic [15:0] dv,
                                              logic [15:0] sv, logic [3:0] cc);
        int unsigned  w;
        int unsigned  mask;
        int unsigned  msb;
        int unsigned  d;
        int unsigned  s;
        int unsigned  cnt;
        int unsigned  res;
        int unsigned  t;
        int unsigned  cin;
        int unsigned  sx;
        logic         neg;
        logic         logic_op;
        logic         set_sz;
        alu_outcome_t o;
        w        = wide ? 16 : 8;
        mask     = wide ? 32'hFFFF : 32'hFF;
        msb      = 1 << (w - 1);
        d        = 32'(dv) & mask;
        s        = 32'(sv) & mask;
        cnt      = 32'(sv[7:0]);
        res      = 0;
        cin      = 0;
        logic_op = 1'b0;
        set_sz   = 1'b1;
        o        = '0;
        o.wb     = 1'b1;
        case (op)
            OP_ADD, OP_ADC:
            begin
                if (op == OP_ADC)
                    cin = 32'(flags.cy);
                t        = d + s + cin;
                res      = t & mask;
                flags.cy = 1'((t >> w) & 1);
                flags.ov = ((~(d ^ s)) & (d ^ res) & msb) != 0;
            end
            OP_SBB, OP_SUB, OP_CMP, OP_NEG:
            begin
                if (op == OP_SBB)
                    cin = 32'(flags.cy);
                if (op == OP_NEG)
                begin
                    s = d;
                    d = 0;
                end
                res      = (d - s - cin) & mask;
                flags.cy = d < s + cin;
                flags.ov = ((d ^ s) & (d ^ res) & msb) != 0;
                if (op == OP_CMP)
                    o.wb = 1'b0;
            end
            OP_OR:
            begin
                res      = d | s;
                logic_op = 1'b1;
            end
            OP_AND:
            begin
                res      = d & s;
                logic_op = 1'b1;
            end
            OP_XOR:
            begin
                res      = d ^ s;
                logic_op = 1'b1;
            end
            OP_TEST:
            begin
                res      = d & s;
                logic_op = 1'b1;
                o.wb     = 1'b0;
            end
            OP_NOT:
            begin
                res    = ~d & mask;
                set_sz = 1'b0;
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                if (cnt == 0)
                begin
                    res    = d;
                    set_sz = 1'b0;
                end
                else if (op == OP_SHL)
                begin
                    res      = (cnt < w) ? ((d << cnt) & mask) : 0;
                    flags.cy = (cnt <= w) ? 1'((d >> (w - cnt)) & 1) : 1'b0;
                    flags.ov = ((res & msb) != 0) ^ flags.cy;
                end
                else if (op == OP_SHR)
                begin
                    res      = (cnt < w) ? (d >> cnt) : 0;
                    flags.cy = (cnt <= w) ? 1'((d >> (cnt - 1)) & 1) : 1'b0;
                    flags.ov = (d & msb) != 0;
                end
                else
                begin
                    neg      = (d & msb) != 0;
                    sx       = neg ? (d | ~mask) : d;
                    res      = (cnt < w) ? ((sx >> cnt) & mask) : (neg ? mask : 0);
                    flags.cy = (cnt <= w) ? 1'((d >> (cnt - 1)) & 1) : neg;
                    flags.ov = 1'b0;
                end
            end
            OP_COND:
            begin
                o.br   = cond_holds(cc);
                o.wb   = 1'b0;
                set_sz = 1'b0;
            end
            default:
            begin
                o.wb   = 1'b0;
                set_sz = 1'b0;
            end
        endcase
        if (logic_op)
        begin
            flags.ov = 1'b0;
            flags.cy = 1'b0;
        end
        if (set_sz)
        begin
            flags.sg = (res & msb) != 0;
            flags.zf = res == 0;
        end
        o.res = res[15:0];
        o.ov  = flags.ov;
        o.cy  = flags.cy;
        o.sg  = flags.sg;
        o.zf  = flags.zf;
        return o;
    endfunction

    function automatic string show(alu_outcome_t o);
        return $sformatf("res=%h wb=%b ov=%b cy=%b sg=%b zf=%b br=%b pad=%b",
                         o.res, o.wb, o.ov, o.cy, o.sg, o.zf, o.br, o.pad);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags = '0;
            outcome_q.delete();
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(alu_step(s_tdata[3:0], s_tuser, s_tdata[19:4],
                                             s_tdata[35:20], s_tdata[39:36]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing expected: %s", $realtime, show(got));
                end
                else
                begin
                    want = outcome_q.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch on result %0d", $realtime, checked);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

/* tb/alu_flags_unit_tb.sv */
// Top of the alu_flags_unit testbench: clock, reset, stimulus, output back-pressure.
// Depends on afu_pkg, alu_flags_unit and afu_flags_checker.
`timescale 1ns / 1ps

module alu_flags_unit_tb;
    import afu_pkg::*;

    localparam logic [3:0] OP_SPARE   = 4'hF;
    localparam int         RAND_ITEMS = 1100;
    localparam int         LONG_HOLD  = 200;
    localparam int         STALL_MAX  = 2000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int sent        = 0;
    bit quiet       = 1'b0;
    int rx_gap      = 0;
    bit hold_done   = 1'b0;
    int idle_cycles = 0;

    alu_flags_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    afu_flags_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stall bursts, one long hold-off, none in the final stretch
    always @(posedge clk)
    begin
        if (rx_gap != 0)
        begin
            rx_gap <= rx_gap - 1;
            if (rx_gap == 1)
                m_tready <= 1'b1;
        end
        else if (!hold_done && sent >= 300)
        begin
            hold_done <= 1'b1;
            rx_gap    <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (!quiet && (checked / 64) % 3 != 1 && $urandom_range(0, 11) == 0)
        begin
            rx_gap   <= $urandom_range(1, 15);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_MAX)
            begin
                $display("Watchdog: no item moved for %0d cycles", STALL_MAX);
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_op(logic [3:0] op, logic wide, logic [15:0] dv, logic [15:0] sv,
                            logic [3:0] cc);
        s_tvalid <= 1'b1;
        s_tdata  <= {cc, sv, dv, op};
        s_tuser  <= wide;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0080;
            5:       return 16'h007F;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [3:0]  op;
        logic        wide;
        logic [15:0] dv;
        logic [15:0] sv;
        logic [3:0]  cc;
        int          pause_at;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(OP_ADD,  1'b0, 16'h00FF, 16'h0001, 4'h0);
        issue_op(OP_ADC,  1'b0, 16'h007F, 16'h0000, 4'h0);
        issue_op(OP_SUB,  1'b1, 16'h0000, 16'h0001, 4'h0);
        issue_op(OP_SBB,  1'b1, 16'h0000, 16'h0000, 4'h0);
        issue_op(OP_SUB,  1'b1, 16'h8000, 16'h0001, 4'h0);
        issue_op(OP_CMP,  1'b0, 16'hFF00, 16'h00FF, 4'h0);
        issue_op(OP_NEG,  1'b1, 16'h8000, 16'hFFFF, 4'h0);
        issue_op(OP_NEG,  1'b0, 16'hFF00, 16'h0000, 4'h0);
        issue_op(OP_OR,   1'b1, 16'hFFFF, 16'h0000, 4'h0);
        issue_op(OP_AND,  1'b1, 16'hFFFF, 16'h0000, 4'h0);
        issue_op(OP_XOR,  1'b0, 16'h12AA, 16'hFF55, 4'h0);
        issue_op(OP_TEST, 1'b1, 16'h8000, 16'hFFFF, 4'h0);
        issue_op(OP_NOT,  1'b1, 16'h0000, 16'h0000, 4'h0);
        issue_op(OP_COND, 1'b0, 16'hFFFF, 16'hFFFF, {CG_BE, 1'b1});
        issue_op(OP_COND, 1'b1, 16'h0000, 16'h0000, {CG_P, 1'b0});
        issue_op(OP_COND, 1'b1, 16'h0000, 16'h0000, {CG_P, 1'b1});
        issue_op(OP_SHL,  1'b1, 16'h1234, 16'hFF00, 4'h0);
        issue_op(OP_SHL,  1'b1, 16'h8001, 16'h0010, 4'h0);
        issue_op(OP_SHL,  1'b0, 16'h0081, 16'h0009, 4'h0);
        issue_op(OP_SHR,  1'b0, 16'h0080, 16'h0008, 4'h0);
        issue_op(OP_SHR,  1'b1, 16'hFFFF, 16'h00FF, 4'h0);
        issue_op(OP_SAR,  1'b1, 16'h8000, 16'h0014, 4'h0);
        issue_op(OP_SAR,  1'b0, 16'h007F, 16'h0008, 4'h0);
        issue_op(OP_COND, 1'b0, 16'h0000, 16'h0000, {CG_LE, 1'b0});
        issue_op(OP_SPARE, 1'b1, 16'hFFFF, 16'hFFFF, 4'hF);
        issue_op(OP_ADD,  1'b1, 16'hFFFF, 16'hFFFF, 4'h0);

        pause_at = $urandom_range(500, 700);
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == pause_at)
                drain();
            quiet = i >= RAND_ITEMS - 150;
            if (!quiet && (sent / 64) % 3 != 2 && $urandom_range(0, 9) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            op   = ($urandom_range(0, 63) == 0) ? OP_SPARE : 4'($urandom_range(0, 14));
            wide = 1'($urandom_range(0, 1));
            dv   = pick_operand();
            sv   = pick_operand();
            cc   = 4'($urandom_range(0, 15));
            if ((op == OP_SHL || op == OP_SHR || op == OP_SAR) && $urandom_range(0, 3) != 0)
                sv[7:0] = 8'($urandom_range(0, 17));
            issue_op(op, wide, dv, sv, cc);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Drove %0d items: every operation and jump condition, byte and word size,",
                 sent);
        $display("shift counts 0 to 255, %0d results compared, %0d failures", checked,
                 fail_count);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/afu_pkg.sv
sv/afu_cond.sv
sv/afu_exec.sv
sv/alu_flags_unit.sv
tb/afu_flags_checker.sv
tb/alu_flags_unit_tb.sv
